[rtl/pxsc_pkg.sv]
// Shared types and constants of the prefix XOR subarray counter.
package pxsc_pkg;

    localparam int VALUE_BITS   = 10;
    localparam int ENTRY_BITS   = 16;
    localparam int TOTAL_BITS   = 32;
    localparam int CFG_BITS     = 10;
    localparam int EPOCH_BITS   = 8;
    localparam int HIST_DEPTH   = 1 << VALUE_BITS;
    localparam int WORD_BITS    = EPOCH_BITS + ENTRY_BITS;
    localparam int OUT_DEPTH    = 3;
    localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

    typedef logic [VALUE_BITS-1:0]   t_value;
    typedef logic [ENTRY_BITS-1:0]   t_entry;
    typedef logic [TOTAL_BITS-1:0]   t_total;
    typedef logic [EPOCH_BITS-1:0]   t_epoch;
    typedef logic [CFG_BITS-1:0]     t_cfg;
    typedef logic [OUT_CNT_BITS-1:0] t_out_cnt;

    // Histogram word: epoch tag plus count.
    typedef struct packed {
        t_epoch tag;
        t_entry count;
    } t_word;

    typedef struct packed {
        t_total match_count;
        logic   final_res;
    } t_result;

    // All-ones tag is never a live epoch; the clearing pass writes it.
    localparam t_epoch EPOCH_IDLE = '1;
    localparam t_epoch EPOCH_LAST = EPOCH_IDLE - t_epoch'(1);
    localparam t_entry ENTRY_MAX  = '1;
    localparam t_total TOTAL_MAX  = '1;

endpackage

[rtl/pxsc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pxsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Read during write to the same address returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/pxsc_out_fifo.sv]
// Small result queue between the histogram stage and the output channel.
module pxsc_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pxsc_pkg::t_result  i_data,
    output pxsc_pkg::t_out_cnt o_count,
    output logic               o_valid,
    input  logic               i_ready,
    output pxsc_pkg::t_result  o_data
);

    pxsc_pkg::t_result                     r_mem [pxsc_pkg::OUT_DEPTH];
    logic [pxsc_pkg::OUT_PTR_BITS-1:0]     r_wr_ptr;
    logic [pxsc_pkg::OUT_PTR_BITS-1:0]     r_rd_ptr;
    pxsc_pkg::t_out_cnt                    r_count;
    logic [pxsc_pkg::OUT_PTR_BITS-1:0]     n_wr_ptr;
    logic [pxsc_pkg::OUT_PTR_BITS-1:0]     n_rd_ptr;
    pxsc_pkg::t_out_cnt                    n_count;
    logic                                  pop;

    localparam logic [pxsc_pkg::OUT_PTR_BITS-1:0] PTR_END =
        pxsc_pkg::OUT_PTR_BITS'(pxsc_pkg::OUT_DEPTH - 1);

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_END) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_END) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/prefix_xor_subarray_counter.sv]
// Top level: streaming count of contiguous runs whose XOR equals a target.
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ---------------------------
//  in        input      i_in_valid / o_in_ready    i_value, i_last
//  out       output     o_out_valid / i_out_ready  o_match_count, o_final_res
//  cfg       input      i_cfg_wr_en (no wait)      i_cfg_wr_data (target_xor)
//
//  One beat per cycle sustained while o_in_ready is high; a result passes
//  through the histogram read in the accept cycle, the read-modify-write in
//  the cycle after it, then a 3-entry result queue. Reset is synchronous,
//  active low. After reset, and after every 255th last beat, a clearing
//  pass sweeps all 1024 entries of the histogram RAM; o_in_ready stays
//  low during it. Sequence ends otherwise reset the histogram at once by
//  bumping an epoch tag stored with each entry. A stalled output holds up
//  input once the queued results plus the beat in stage 1 add up to three.
module prefix_xor_subarray_counter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [pxsc_pkg::VALUE_BITS-1:0] i_value,
    input  logic                           i_last,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [pxsc_pkg::TOTAL_BITS-1:0] o_match_count,
    output logic                           o_final_res,
    input  logic                           i_cfg_wr_en,
    input  logic [pxsc_pkg::CFG_BITS-1:0]   i_cfg_wr_data
);

    // ---------------------------------------------------------------- state
    pxsc_pkg::t_value  r_target;
    pxsc_pkg::t_value  r_xor;
    pxsc_pkg::t_epoch  r_epoch;
    pxsc_pkg::t_total  r_total;
    logic              r_clearing;
    pxsc_pkg::t_value  r_clr_addr;

    // stage 1: RAM data arrives for the beat accepted last cycle
    logic              r_s1_valid;
    pxsc_pkg::t_value  r_s1_p;
    pxsc_pkg::t_value  r_s1_partner;
    logic              r_s1_last;
    pxsc_pkg::t_epoch  r_s1_epoch;

    // write of the previous cycle, for bypass of a stale RAM read
    logic              r_fwd_valid;
    pxsc_pkg::t_value  r_fwd_addr;
    pxsc_pkg::t_entry  r_fwd_count;

    // ---------------------------------------------------------------- wires
    logic              in_accept;
    pxsc_pkg::t_value  p0;
    pxsc_pkg::t_value  partner0;
    pxsc_pkg::t_word   rd_partner_word;
    pxsc_pkg::t_word   rd_p_word;
    pxsc_pkg::t_entry  cnt_partner;
    pxsc_pkg::t_entry  cnt_p;
    pxsc_pkg::t_entry  cnt_p_inc;
    logic [pxsc_pkg::TOTAL_BITS:0] sum;
    pxsc_pkg::t_total  total_sat;
    logic              hist_wr;
    logic              ram_wr_en;
    pxsc_pkg::t_value  ram_wr_addr;
    pxsc_pkg::t_word   ram_wr_data;
    pxsc_pkg::t_result s1_result;
    pxsc_pkg::t_result out_result;
    pxsc_pkg::t_out_cnt fifo_count;
    logic [pxsc_pkg::OUT_CNT_BITS:0] in_flight;

    // Entry value as seen by the current epoch; bypass wins over the RAM.
    function automatic pxsc_pkg::t_entry resolve(
        input pxsc_pkg::t_word  word,
        input pxsc_pkg::t_value addr,
        input pxsc_pkg::t_epoch epoch,
        input logic             fwd_valid,
        input pxsc_pkg::t_value fwd_addr,
        input pxsc_pkg::t_entry fwd_count
    );
        pxsc_pkg::t_entry res;
        if (fwd_valid && (fwd_addr == addr)) begin
            res = fwd_count;
        end else if (word.tag == epoch) begin
            res = word.count;
        end else begin
            // untouched in this sequence: empty prefix counts once at zero
            res = (addr == '0) ? pxsc_pkg::t_entry'(1) : '0;
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- stage 0
    assign in_flight  = {1'b0, fifo_count} + (pxsc_pkg::OUT_CNT_BITS + 1)'(r_s1_valid);
    assign o_in_ready = !r_clearing &&
                        (in_flight < (pxsc_pkg::OUT_CNT_BITS + 1)'(pxsc_pkg::OUT_DEPTH));
    assign in_accept  = i_in_valid && o_in_ready;
    assign p0         = r_xor ^ i_value;
    assign partner0   = p0 ^ r_target;

    // ---------------------------------------------------------------- stage 1
    always_comb begin
        cnt_partner = resolve(rd_partner_word, r_s1_partner, r_s1_epoch,
                              r_fwd_valid, r_fwd_addr, r_fwd_count);
        cnt_p       = resolve(rd_p_word, r_s1_p, r_s1_epoch,
                              r_fwd_valid, r_fwd_addr, r_fwd_count);
        cnt_p_inc   = (cnt_p == pxsc_pkg::ENTRY_MAX) ? cnt_p : cnt_p + 1'b1;
        sum         = {1'b0, r_total} +
                      (pxsc_pkg::TOTAL_BITS + 1)'(cnt_partner);
        total_sat   = sum[pxsc_pkg::TOTAL_BITS] ? pxsc_pkg::TOTAL_MAX
                                                : sum[pxsc_pkg::TOTAL_BITS-1:0];
    end

    // A last beat skips its write: the epoch bump retires the sequence.
    assign hist_wr = r_s1_valid && !r_s1_last;

    always_comb begin
        if (r_clearing) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_clr_addr;
            ram_wr_data = '{tag: pxsc_pkg::EPOCH_IDLE, count: '0};
        end else begin
            ram_wr_en   = hist_wr;
            ram_wr_addr = r_s1_p;
            ram_wr_data = '{tag: r_s1_epoch, count: cnt_p_inc};
        end
    end

    assign s1_result = '{match_count: total_sat, final_res: r_s1_last};

    // Two copies of the histogram, written alike, one read port each.
    pxsc_ram #(
        .WIDTH (pxsc_pkg::WORD_BITS),
        .DEPTH (pxsc_pkg::HIST_DEPTH)
    ) u_hist_partner (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (partner0),
        .o_rd_data (rd_partner_word)
    );

    pxsc_ram #(
        .WIDTH (pxsc_pkg::WORD_BITS),
        .DEPTH (pxsc_pkg::HIST_DEPTH)
    ) u_hist_prefix (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (p0),
        .o_rd_data (rd_p_word)
    );

    pxsc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (s1_result),
        .o_count (fifo_count),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_result)
    );

    assign o_match_count = out_result.match_count;
    assign o_final_res   = out_result.final_res;

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_xor       <= '0;
            r_epoch     <= '0;
            r_total     <= '0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_target <= pxsc_pkg::VALUE_BITS'(i_cfg_wr_data);
            end

            r_s1_valid  <= in_accept;
            r_fwd_valid <= hist_wr && !r_clearing;

            if (in_accept) begin
                r_xor <= i_last ? '0 : p0;
                if (i_last) begin
                    if (r_epoch == pxsc_pkg::EPOCH_LAST) begin
                        r_epoch    <= '0;
                        r_clearing <= 1'b1;
                        r_clr_addr <= '0;
                    end else begin
                        r_epoch <= r_epoch + 1'b1;
                    end
                end
            end

            if (r_s1_valid) begin
                r_total <= r_s1_last ? '0 : total_sat;
            end

            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_p       <= p0;
            r_s1_partner <= partner0;
            r_s1_last    <= i_last;
            r_s1_epoch   <= r_epoch;
        end
        r_fwd_addr  <= r_s1_p;
        r_fwd_count <= cnt_p_inc;
    end

    // ---------------------------------------------------------------- checks
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (fifo_count < pxsc_pkg::OUT_CNT_BITS'(pxsc_pkg::OUT_DEPTH)))
        else $error("result queue overflow");

    a_clear_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clearing && r_s1_valid) |-> r_s1_last)
        else $error("histogram write collides with clearing pass");

    a_live_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != pxsc_pkg::EPOCH_IDLE)
        else $error("epoch reached reserved tag");

    a_total_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |=> (r_total == '0))
        else $error("total not cleared after last beat");

endmodule

[sim/pxsc_tb_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard class for the prefix XOR subarray counter testbench.
package pxsc_tb_pkg;
    import pxsc_pkg::*;

    class xor_run_scoreboard;
        t_value      target;
        t_value      prefix;
        int unsigned seen[HIST_DEPTH];
        t_total      total;
        t_result     expected_q[$];
        int          mismatches;

        function new();
            target     = '0;
            mismatches = 0;
            restart_sequence();
        endfunction

        // Sequence state back to its idle values; target is kept.
        function void restart_sequence();
            foreach (seen[i]) seen[i] = 0;
            seen[0] = 1;    // empty prefix
            prefix  = '0;
            total   = '0;
        endfunction

        function void set_target(input t_cfg v);
            target = t_value'(v);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_failure(input string msg);
            mismatches++;
            if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
        endfunction

        // Accepted input beat: fold it in and queue the expected result.
        function void note_input(input t_value v, input logic last_mark);
            t_value          partner;
            longint unsigned sum;
            t_result         r;
            prefix  = prefix ^ v;
            partner = prefix ^ target;
            sum     = 64'(total) + 64'(seen[partner]);
            total   = (sum > 64'(TOTAL_MAX)) ? TOTAL_MAX : t_total'(sum);
            if (seen[prefix] < ENTRY_MAX) seen[prefix]++;
            r.match_count = total;
            r.final_res   = last_mark;
            expected_q.push_back(r);
            if (last_mark) restart_sequence();
        endfunction

        // Accepted output beat: compare against the oldest expectation.
        function void check_result(input t_total count, input logic fin);
            t_result want;
            if (expected_q.size() == 0) begin
                note_failure($sformatf("unexpected result count=%0d final=%0b", count, fin));
                return;
            end
            want = expected_q.pop_front();
            if (want.match_count !== count)
                note_failure($sformatf("match_count exp=%0d act=%0d",
                                       want.match_count, count));
            if (want.final_res !== fin)
                note_failure($sformatf("final_res exp=%0b act=%0b", want.final_res, fin));
        endfunction
    endclass

endpackage

[sim/tb_prefix_xor_subarray_counter.sv]
`timescale 1ns / 100ps
// Testbench top: drives the XOR subarray counter and scores every result beat.
module tb_prefix_xor_subarray_counter;
    import pxsc_pkg::*;
    import pxsc_tb_pkg::*;

    // No-progress limit: covers the full histogram sweep plus the longest
    // gap / stall with plenty of margin.
    localparam int STALL_LIMIT   = 4096;
    // Long all-zero run, target 0: every prefix repeats, matches pile up.
    localparam int ZERO_RUN      = 200;
    localparam int RANDOM_BEATS  = 1000;
    localparam int RANDOM_PHASES = 4;
    localparam int DRAIN_SETTLE  = 8;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_ready;
    t_value i_value;
    logic   i_last;
    logic   o_out_valid;
    logic   i_out_ready;
    t_total o_match_count;
    logic   o_final_res;
    logic   i_cfg_wr_en;
    t_cfg   i_cfg_wr_data;

    xor_run_scoreboard sb;
    bit     in_steady;      // sender: no gaps while set
    bit     out_steady;     // receiver: no stalls while set
    t_value cur_target;

    wire in_fire  = i_in_valid && o_in_ready;
    wire out_fire = o_out_valid && i_out_ready;

    prefix_xor_subarray_counter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_value       (i_value),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_match_count (o_match_count),
        .o_final_res   (o_final_res),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly very short sequences so that many sequence ends occur
    // (the 255th end triggers a full histogram sweep in the block).
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 10);
        return $urandom_range(11, 40);
    endfunction

    // Monitor: both channels sampled at the edge, pre-update values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire) sb.note_input(i_value, i_last);
            if (out_fire) sb.check_result(o_match_count, o_final_res);
        end
    end

    // Receiver: random ready pattern, or steady ready when out_steady is set.
    initial begin : out_ready_driver
        int   hold;
        logic ready_now;
        hold        = 0;
        ready_now   = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_steady) begin
                ready_now = 1'b1;
                hold      = 0;
            end else if (hold > 0) begin
                hold--;
            end else if (ready_now) begin
                hold      = pick_gap();
                ready_now = (hold == 0);
                if (ready_now) hold = $urandom_range(0, 15);
            end else begin
                ready_now = 1'b1;
                hold      = $urandom_range(0, 15);
            end
            i_out_ready <= ready_now;
        end
    end

    // Watchdog: ends the run if neither channel moves a beat for too long.
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (in_fire || out_fire) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // One input beat; returns at the edge where it is accepted.
    task automatic send_beat(input t_value v, input logic last_mark);
        int gap;
        gap = in_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        i_last     <= last_mark;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Sender holds off until every expected result is back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    // Only called with the block idle (after drain_results).
    task automatic write_target(input t_cfg v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_target(v);
        cur_target = t_value'(v);
    endtask

    // Whole sequence, last mark on the final beat. Most sequences draw from a
    // small pool (zero, the target, two randoms) so prefixes repeat and
    // matches pile up; the rest use fully random values.
    task automatic send_sequence(input int len);
        t_value pool[4];
        bit     pooled;
        pooled  = ($urandom_range(0, 9) < 6);
        pool[0] = '0;
        pool[1] = cur_target;
        pool[2] = t_value'($urandom);
        pool[3] = t_value'($urandom);
        for (int k = 0; k < len; k++)
            send_beat(pooled ? pool[$urandom_range(0, 3)] : t_value'($urandom), k == len - 1);
    endtask

    initial begin : main
        int sent;
        sb = new();
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_value       <= '0;
        i_last        <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        in_steady  = 1'b0;
        out_steady = 1'b0;
        cur_target = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: target at its reset value first.
        send_beat(t_value'(0), 1'b0);           // empty prefix match
        send_beat(t_value'(10'h3FF), 1'b0);
        send_beat(t_value'(10'h3FF), 1'b0);
        send_beat(t_value'(0), 1'b1);
        send_beat(t_value'(10'h3FF), 1'b1);     // single-beat sequence
        drain_results();

        // All-ones target.
        write_target(t_cfg'(10'h3FF));
        send_beat(t_value'(10'h3FF), 1'b1);
        send_beat(t_value'(10'h155), 1'b0);
        send_beat(t_value'(10'h2AA), 1'b0);
        send_beat(t_value'(10'h3FF), 1'b0);
        send_beat(t_value'(0), 1'b0);
        send_beat(t_value'(10'h3FF), 1'b1);
        drain_results();

        // Alternating-bit target, repeated pattern gives several matches.
        write_target(t_cfg'(10'h2AA));
        send_beat(t_value'(10'h2AA), 1'b0);
        send_beat(t_value'(10'h155), 1'b0);
        send_beat(t_value'(10'h3FF), 1'b0);
        send_beat(t_value'(10'h2AA), 1'b0);
        send_beat(t_value'(10'h155), 1'b1);
        drain_results();

        // One long all-zero sequence with target zero, hitting the same
        // entry every beat. Both sides run flat out to keep it at one beat
        // per cycle.
        write_target(t_cfg'(0));
        in_steady  = 1'b1;
        out_steady = 1'b1;
        for (int k = 0; k < ZERO_RUN; k++)
            send_beat(t_value'(0), k == ZERO_RUN - 1);
        in_steady  = 1'b0;
        out_steady = 1'b0;
        drain_results();

        // Random part: a few target settings, whole sequences per phase.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                1:       write_target(t_cfg'(10'h3FF));
                2:       write_target(t_cfg'($urandom_range(0, 3)));
                default: write_target(t_cfg'($urandom));
            endcase
            sent = 0;
            while (sent < RANDOM_BEATS / RANDOM_PHASES) begin
                // Occasional stretch with no idling on either side.
                in_steady  = ($urandom_range(0, 99) < 15);
                out_steady = in_steady;
                begin
                    int len;
                    len = pick_len();
                    send_sequence(len);
                    sent += len;
                end
            end
            in_steady  = 1'b0;
            out_steady = 1'b0;
            drain_results();
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
